@@ sv/lkv_pkg.sv @@
package lkv_pkg;

	// port field widths
	localparam int KEY_W   = 64;
	localparam int VALUE_W = 64;
	localparam int OCC_W   = 4;
	localparam int CAP_W   = 4;

	// capacity register
	localparam logic [CAP_W-1:0] CAP_RESET    = 4'd5;
	localparam logic             REG_CAPACITY = 1'b0;

	// operation codes
	typedef enum logic [1:0] {
		CMD_SET    = 2'd0,
		CMD_GET    = 2'd1,
		CMD_DELETE = 2'd2
	} cmd_t;

	// result of one operation
	typedef struct packed {
		logic               found;
		logic [VALUE_W-1:0] read_value;
		logic [OCC_W-1:0]   occupancy;
	} lkv_result_t;

endpackage

@@ sv/lkv_store.sv @@
module lkv_store import lkv_pkg::*; #(
	parameter int ENTRIES    = 8,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  cmd_t               cmd,
	input  logic [KEY_W-1:0]   key,
	input  logic [VALUE_W-1:0] value,
	input  logic [CAP_W-1:0]   capacity,
	output lkv_result_t        res
);

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	logic [ENTRIES-1:0]    valid_q;
	logic [KEY_BITS-1:0]   key_q   [ENTRIES];
	logic [VALUE_BITS-1:0] value_q [ENTRIES];
	logic [AW-1:0]         age_q   [ENTRIES];
	logic [CW-1:0]         count_q;

	logic [KEY_BITS-1:0]   key_m;
	logic [ENTRIES-1:0]    match;
	logic [ENTRIES-1:0]    hit_oh;
	logic                  hit;
	logic [AW-1:0]         hit_age;
	logic [VALUE_BITS-1:0] hit_value;
	logic [LW-1:0]         lim;
	logic                  full;
	logic [AW-1:0]         oldest_age;
	logic [ENTRIES-1:0]    lru_oh;
	logic [ENTRIES-1:0]    evict_oh;
	logic [ENTRIES-1:0]    free;
	logic [ENTRIES-1:0]    free_oh;
	logic [ENTRIES-1:0]    valid_d;
	logic [AW-1:0]         age_d   [ENTRIES];
	logic [CW-1:0]         count_d;
	logic [ENTRIES-1:0]    wr_key_oh;
	logic [ENTRIES-1:0]    wr_val_oh;
	logic [VALUE_BITS-1:0] rd;

	assign key_m = key[KEY_BITS-1:0];

	// parallel key search, lowest matching slot wins
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key_m);
		end
	end

	assign hit_oh = match & (~match + 1'b1);
	assign hit    = |match;

	always_comb begin
		hit_age   = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_oh[i]) begin
				hit_age   = hit_age | age_q[i];
				hit_value = hit_value | value_q[i];
			end
		end
	end

	// effective capacity, clamped to 1..ENTRIES
	always_comb begin
		if (capacity == '0) begin
			lim = LW'(1);
		end else if (LW'(capacity) > LW'(ENTRIES)) begin
			lim = LW'(ENTRIES);
		end else begin
			lim = LW'(capacity);
		end
	end

	assign full = LW'(count_q) >= lim;

	// ranks are unique, so the oldest entry holds rank count-1
	assign oldest_age = AW'(count_q - 1'b1);

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			lru_oh[i] = valid_q[i] && (age_q[i] == oldest_age);
		end
	end

	assign evict_oh = (cmd == CMD_SET && !hit && full) ? lru_oh : '0;
	assign free     = ~(valid_q & ~evict_oh);
	assign free_oh  = free & (~free + 1'b1);

	// next entry state
	always_comb begin
		valid_d   = valid_q;
		age_d     = age_q;
		count_d   = count_q;
		wr_key_oh = '0;
		wr_val_oh = '0;
		rd        = '0;
		case (cmd)
			CMD_SET: begin
				if (hit) begin
					wr_val_oh = hit_oh;
					for (int j = 0; j < ENTRIES; j++) begin
						if (hit_oh[j]) begin
							age_d[j] = '0;
						end else if (valid_q[j] && age_q[j] < hit_age) begin
							age_d[j] = age_q[j] + 1'b1;
						end
					end
				end else begin
					wr_key_oh = free_oh;
					wr_val_oh = free_oh;
					valid_d   = (valid_q & ~evict_oh) | free_oh;
					for (int j = 0; j < ENTRIES; j++) begin
						if (free_oh[j]) begin
							age_d[j] = '0;
						end else if (valid_q[j] && !evict_oh[j]) begin
							age_d[j] = age_q[j] + 1'b1;
						end
					end
					if (|evict_oh) begin
						count_d = count_q;
					end else begin
						count_d = count_q + 1'b1;
					end
				end
			end
			CMD_GET: begin
				if (hit) begin
					rd = hit_value;
					for (int j = 0; j < ENTRIES; j++) begin
						if (hit_oh[j]) begin
							age_d[j] = '0;
						end else if (valid_q[j] && age_q[j] < hit_age) begin
							age_d[j] = age_q[j] + 1'b1;
						end
					end
				end
			end
			CMD_DELETE: begin
				if (hit) begin
					valid_d = valid_q & ~hit_oh;
					count_d = count_q - 1'b1;
					for (int j = 0; j < ENTRIES; j++) begin
						if (hit_oh[j]) begin
							age_d[j] = '0;
						end else if (valid_q[j] && age_q[j] > hit_age) begin
							age_d[j] = age_q[j] - 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else if (upd) begin
			valid_q <= valid_d;
			count_q <= count_d;
			age_q   <= age_d;
		end
	end

	// key and value payload
	always_ff @(posedge clk) begin
		if (upd) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (wr_key_oh[i]) begin
					key_q[i] <= key_m;
				end
				if (wr_val_oh[i]) begin
					value_q[i] <= value[VALUE_BITS-1:0];
				end
			end
		end
	end

	assign res.found      = hit;
	assign res.read_value = VALUE_W'(rd);
	assign res.occupancy  = OCC_W'(count_d);

endmodule

@@ sv/lkv_outbuf.sv @@
module lkv_outbuf import lkv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  lkv_result_t push_res,
	output logic        push_ready,
	output logic        pop_valid,
	input  logic        pop_ready,
	output lkv_result_t pop_res
);

	logic        out_valid_q;
	logic        skid_valid_q;
	lkv_result_t out_q;
	lkv_result_t skid_q;
	logic        pop;

	assign pop        = out_valid_q && pop_ready;
	assign push_ready = !skid_valid_q;
	assign pop_valid  = out_valid_q;
	assign pop_res    = out_q;

	// output register with one skid slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload moves
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_res;
			end else begin
				out_q <= push_res;
			end
		end
	end

endmodule

@@ sv/lru_key_value_cache.sv @@
// channel   direction  fields (lsb first)
// s_*       in         tuser: command; tdata: key, value
// m_*       out        tuser: found; tdata: read_value, occupancy, zero pad
// apb       in/out     capacity at byte address 0
//
// one input beat per cycle while s_tready is high; key search and recency update finish in that cycle
// the result is in the output register the cycle after acceptance if that register
//   is empty or being read, otherwise it waits in a skid slot behind it
// s_tready is low while the skid slot is full, at least the cycle after it fills
// reset empties the cache and the output buffer and sets capacity to 5
module lru_key_value_cache import lkv_pkg::*; #(
	parameter int ENTRIES    = 8,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // key[63:0], value[127:64]
	input  logic [1:0]   s_tuser,   // command[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,   // read_value[63:0], occupancy[67:64], zero[71:68]
	output logic         m_tuser,   // found
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [CAP_W-1:0] capacity_q;
	logic             accept;
	lkv_result_t      res;
	lkv_result_t      out_res;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_q) : '0;

	assign accept = s_tvalid && s_tready;

	lkv_store #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (accept),
		.cmd      (cmd_t'(s_tuser)),
		.key      (s_tdata[KEY_W-1:0]),
		.value    (s_tdata[KEY_W+VALUE_W-1:KEY_W]),
		.capacity (capacity_q),
		.res      (res)
	);

	lkv_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_res   (res),
		.push_ready (s_tready),
		.pop_valid  (m_tvalid),
		.pop_ready  (m_tready),
		.pop_res    (out_res)
	);

	// result beat packing
	assign m_tuser = out_res.found;
	assign m_tdata = {4'b0000, out_res.occupancy, out_res.read_value};

endmodule

@@ sv/lkv_checker.sv @@
module lkv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser
);

	// output is empty while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result beat valid during reset");

	// input only stalls when a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no pending result");

	// a miss never returns a value
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[63:0] == 64'd0)
		else $error("miss returned a nonzero value");

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ bench/lru_cache_checker.sv @@
module lru_cache_checker import lkv_pkg::*; #(
	parameter int ENTRIES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,   // key[63:0], value[127:64]
	input  logic [1:0]   s_tuser,   // command[1:0]
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [71:0]  m_tdata,   // read_value[63:0], occupancy[67:64], zero[71:68]
	input  logic         m_tuser,   // found
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic [31:0]  prdata,
	input  logic         pready,
	output int           fail_count,
	output int           pending
);

	localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

	// shadow copy of the cache contents and recency ranks
	logic               live [ENTRIES];
	logic [KEY_W-1:0]   tag  [ENTRIES];
	logic [VALUE_W-1:0] data [ENTRIES];
	int unsigned        rank [ENTRIES];
	logic [CAP_W-1:0]   capacity;

	lkv_result_t pending_results[$];

	function automatic int unsigned live_count();
		int unsigned n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (live[i])
				n++;
		return n;
	endfunction

	// capacity clamped to 1..ENTRIES
	function automatic int unsigned effective_capacity();
		int unsigned c;
		c = 32'(capacity);
		if (c == 0)
			c = 1;
		if (c > ENTRIES)
			c = ENTRIES;
		return c;
	endfunction

	function automatic void promote(int h);
		for (int j = 0; j < ENTRIES; j++)
			if (live[j] && j != h && rank[j] < rank[h])
				rank[j]++;
		rank[h] = 0;
	endfunction

	function automatic void drop_slot(int h);
		live[h] = 1'b0;
		for (int j = 0; j < ENTRIES; j++)
			if (live[j] && rank[j] > rank[h])
				rank[j]--;
		rank[h] = 0;
	endfunction

	// apply one operation to the shadow cache and return its result
	function automatic lkv_result_t cache_access(logic [1:0] cmd, logic [KEY_W-1:0] k,
			logic [VALUE_W-1:0] v);
		lkv_result_t r;
		logic        hit;
		int          hit_idx;
		int          lru_idx;
		int          free_idx;
		int unsigned oldest;
		hit      = 1'b0;
		hit_idx  = 0;
		r        = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!hit && live[i] && tag[i] == k) begin
				hit     = 1'b1;
				hit_idx = i;
			end
		end
		case (cmd)
			CMD_SET: begin
				if (hit) begin
					data[hit_idx] = v;
					promote(hit_idx);
				end else begin
					// full: evict only the single least recent entry
					if (live_count() >= effective_capacity()) begin
						lru_idx = -1;
						oldest  = 0;
						for (int i = 0; i < ENTRIES; i++) begin
							if (live[i] && (lru_idx < 0 || rank[i] > oldest)) begin
								lru_idx = i;
								oldest  = rank[i];
							end
						end
						if (lru_idx >= 0)
							drop_slot(lru_idx);
					end
					// lowest free slot takes the new entry
					free_idx = -1;
					for (int i = 0; i < ENTRIES; i++)
						if (free_idx < 0 && !live[i])
							free_idx = i;
					if (free_idx >= 0) begin
						for (int j = 0; j < ENTRIES; j++)
							if (live[j])
								rank[j]++;
						live[free_idx] = 1'b1;
						tag[free_idx]  = k;
						data[free_idx] = v;
						rank[free_idx] = 0;
					end
				end
			end
			CMD_GET: begin
				if (hit) begin
					promote(hit_idx);
					r.read_value = data[hit_idx];
				end
			end
			CMD_DELETE: begin
				if (hit)
					drop_slot(hit_idx);
			end
			default: ;
		endcase
		r.found     = hit;
		r.occupancy = OCC_W'(live_count());
		return r;
	endfunction

	// watch config port, input and output channels
	always @(posedge clk or negedge arst_n) begin
		lkv_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				live[i] = 1'b0;
				tag[i]  = '0;
				data[i] = '0;
				rank[i] = 0;
			end
			capacity = CAP_RESET;
			pending_results.delete();
		end else begin
			// register access
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == CAPACITY_ADDR)
						capacity = pwdata[CAP_W-1:0];
				end else if (paddr == CAPACITY_ADDR && prdata !== 32'(capacity)) begin
					$error("capacity readback: expected %0d, got %0d", capacity, prdata);
					fail_count++;
				end
			end

			// result beat against oldest prediction
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing outstanding");
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (m_tuser !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, m_tuser);
						fail_count++;
					end
					if (m_tdata[VALUE_W-1:0] !== want.read_value) begin
						$error("read_value: expected %h, got %h", want.read_value,
							m_tdata[VALUE_W-1:0]);
						fail_count++;
					end
					if (m_tdata[VALUE_W +: OCC_W] !== want.occupancy) begin
						$error("occupancy: expected %0d, got %0d", want.occupancy,
							m_tdata[VALUE_W +: OCC_W]);
						fail_count++;
					end
					if (m_tdata[71:VALUE_W+OCC_W] !== '0) begin
						$error("pad: expected 0, got %h", m_tdata[71:VALUE_W+OCC_W]);
						fail_count++;
					end
				end
			end

			// accepted command beat
			if (s_tvalid && s_tready)
				pending_results.push_back(cache_access(s_tuser, s_tdata[KEY_W-1:0],
					s_tdata[KEY_W +: VALUE_W]));
		end
		pending = pending_results.size();
	end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
	import lkv_pkg::*;

	localparam logic [1:0] CMD_UNUSED    = 2'd3;
	localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
	localparam int         POOL_SIZE     = 10;
	localparam int         PHASE_ITEMS   = 48;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b1;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata  = '0;
	logic [1:0]   s_tuser  = CMD_SET;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;
	logic         m_tuser;
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [2:0]   paddr    = '0;
	logic [31:0]  pwdata   = '0;
	logic [31:0]  prdata;
	logic         pready;

	int fail_count;
	int pending;

	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	lru_key_value_cache dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	lru_cache_checker #(.ENTRIES(8)) chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver backpressure: modes of always ready, coin flip, mostly stalled
	int ready_mode = 0;
	int mode_left  = 0;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= $urandom_range(0, 2);
			mode_left  <= $urandom_range(10, 60);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_beat(input logic [1:0] cmd, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {v, k};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// register access, setup phase then access phase
	task automatic reg_access(input logic wr, input logic [31:0] wdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= CAPACITY_ADDR;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		wait_drained();
		reg_access(1'b1, {28'($urandom_range(0, 32'h0fff_ffff)), cap});
		reg_access(1'b0, '0);
	endtask

	task automatic random_op();
		int               pick;
		logic [1:0]       cmd;
		logic [KEY_W-1:0] k;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			cmd = CMD_SET;
		else if (pick < 80)
			cmd = CMD_GET;
		else if (pick < 95)
			cmd = CMD_DELETE;
		else
			cmd = CMD_UNUSED;
		if ($urandom_range(0, 99) < 85)
			k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			k = {$urandom, $urandom};
		send_beat(cmd, k, {$urandom, $urandom});
	endtask

	// random phase: bursts of beats separated by random gaps, optionally drained midway
	task automatic run_phase(input int items, input bit pause_midway);
		int burst_left;
		int gap;
		burst_left = 0;
		for (int n = 0; n < items; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			if (pause_midway && n == items / 2)
				wait_drained();
			random_op();
			burst_left--;
		end
	endtask

	initial begin
		logic [CAP_W-1:0] caps [8];
		caps = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd1, 4'd9, 4'd5, 4'd0};
		caps[7] = CAP_W'($urandom_range(0, 15));

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = {$urandom, $urandom};

		// reset edge after time zero so every process sees it
		#1 arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty cache, extremes, overwrite, unused command, eviction
		send_beat(CMD_GET, key_pool[0], '1);
		send_beat(CMD_DELETE, key_pool[0], '0);
		send_beat(CMD_SET, key_pool[0], '1);
		send_beat(CMD_SET, key_pool[1], '0);
		send_beat(CMD_GET, key_pool[0], '0);
		send_beat(CMD_GET, key_pool[1], '1);
		send_beat(CMD_UNUSED, key_pool[0], '1);
		send_beat(CMD_UNUSED, key_pool[5], '1);
		send_beat(CMD_SET, key_pool[0], 64'h0123_4567_89ab_cdef);
		send_beat(CMD_DELETE, key_pool[1], '1);
		for (int i = 2; i <= 6; i++)
			send_beat(CMD_SET, key_pool[i], {$urandom, $urandom});
		send_beat(CMD_GET, key_pool[0], '0);
		send_beat(CMD_GET, key_pool[2], '0);
		send_beat(CMD_SET, key_pool[7], 64'hfedc_ba98_7654_3210);
		send_beat(CMD_GET, key_pool[3], '0);
		send_beat(CMD_DELETE, key_pool[2], '0);

		// capacity sweep: max, lowered below occupancy, zero, above range, ...
		for (int p = 0; p < 8; p++) begin
			set_capacity(caps[p]);
			run_phase(PHASE_ITEMS, p == 2);
		end

		wait_drained();
		repeat (4) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
